@@ rtl/ihist_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihist_pkg
// Beat types, item kinds and register indexes of the integral histogram tile.
// ----------------------------------------------------------------------------
package ihist_pkg;

  // position counters cover the 9-bit geometry registers
  localparam int POS_W      = 9;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_STRIDE  = 8'd3;

  // item kinds; the remaining code is ignored
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_WEST  = 2'd1;
  localparam logic [1:0] KIND_NORTH = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pixel_value;
    logic [7:0]  halo_index;
    logic [3:0]  halo_bin;
    logic [31:0] halo_value;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  bin_index;
    logic [31:0] row_count;
    logic [31:0] total_count;
    logic [7:0]  pixel_column;
    logic [7:0]  pixel_row;
    logic        last_bin;
    logic        east_edge;
    logic        south_edge;
  } out_beat_t;

endpackage

@@ rtl/ihist_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihist_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ihist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port; read data holds when re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/integral_histogram_tile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integral_histogram_tile
// Integral histogram of an image tile in raster order, with west and north
// halos loaded ahead of the pixels and one count beat per bin per pixel.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid / in_stall  | ihist_pkg::in_beat_t
//   out     | output    | out_valid / out_stall| ihist_pkg::out_beat_t
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// A pixel is worked as one read-modify-write of the line memory per bin in
// use, with the west memory read per bin and written back on the east edge,
// and the read of the next bin overlapping the update of the current one.
// Reset is synchronous, active low, clears control state and presets the registers;
// both memories are undefined until loaded. A stalled output beat freezes the
// bin loop in place; in_stall is high while a pixel is being worked on.
//
module integral_histogram_tile #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_BINS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ihist_pkg::in_beat_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ihist_pkg::out_beat_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ihist_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ihist_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ihist_pkg::*;

  localparam int BW     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int KW     = $clog2(MAX_BINS + 1);
  localparam int LDEPTH = MAX_WIDTH * MAX_BINS;
  localparam int WDEPTH = MAX_HEIGHT * MAX_BINS;
  localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int ACC_W  = KW + 17;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t            state_r;
  logic [8:0]        tile_width_r;
  logic [8:0]        tile_height_r;
  logic [4:0]        bin_count_r;
  logic [15:0]       bin_stride_r;
  logic [POS_W-1:0]  col_pos_r;
  logic [POS_W-1:0]  row_pos_r;

  // pixel context
  logic [POS_W-1:0]  col_r;
  logic [POS_W-1:0]  row_r;
  logic              east_r;
  logic              south_r;
  logic [15:0]       p256_r;
  logic [KW-1:0]     nb_r;

  // bin loop
  logic [KW-1:0]     iss_r;
  logic              rv_r;
  logic [BW-1:0]     rb_r;
  logic [ACC_W-1:0]  acc_r;
  logic [LAW-1:0]    line_wa_r;
  logic [WAW-1:0]    west_wa_r;
  logic [31:0]       row_run_r [MAX_BINS];

  logic              out_valid_r;
  out_beat_t         out_data_r;

  logic [POS_W-1:0]  w_eff;
  logic [POS_W-1:0]  h_eff;
  logic [KW-1:0]     nb_eff;
  logic [POS_W-1:0]  col_eff;
  logic [POS_W-1:0]  row_eff;
  logic [POS_W-1:0]  col_inc;
  logic [POS_W-1:0]  row_inc;
  logic              accept;
  logic              pix_acc;
  logic              north_ld;
  logic              west_ld;
  logic [LAW-1:0]    north_ld_addr;
  logic [WAW-1:0]    west_ld_addr;
  logic              advance;
  logic              issue;
  logic              compute;
  logic              finish;
  logic [LAW-1:0]    line_ra;
  logic [WAW-1:0]    west_ra;
  logic              hit;
  logic [31:0]       prev;
  logic [31:0]       rc;
  logic [31:0]       tc;
  logic              line_we;
  logic [LAW-1:0]    line_waddr;
  logic [31:0]       line_wdata;
  logic [31:0]       line_rdata;
  logic              west_we;
  logic [WAW-1:0]    west_waddr;
  logic [31:0]       west_wdata;
  logic [31:0]       west_rdata;
  logic              last_now;

  // effective geometry and bin count
  always_comb begin
    if (tile_width_r == 9'd0) begin
      w_eff = POS_W'(1);
    end else if (32'(tile_width_r) > MAX_WIDTH) begin
      w_eff = POS_W'(MAX_WIDTH);
    end else begin
      w_eff = tile_width_r;
    end
    if (tile_height_r == 9'd0) begin
      h_eff = POS_W'(1);
    end else if (32'(tile_height_r) > MAX_HEIGHT) begin
      h_eff = POS_W'(MAX_HEIGHT);
    end else begin
      h_eff = tile_height_r;
    end
    if (32'(bin_count_r) > MAX_BINS) begin
      nb_eff = KW'(MAX_BINS);
    end else begin
      nb_eff = KW'(bin_count_r);
    end
  end

  // position of the incoming pixel and the one after it
  always_comb begin
    col_eff = (col_pos_r >= w_eff) ? '0 : col_pos_r;
    row_eff = (row_pos_r >= h_eff) ? '0 : row_pos_r;
    col_inc = col_eff + POS_W'(1);
    row_inc = row_eff + POS_W'(1);
  end

  // input handshake and halo loads
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign pix_acc  = accept && (in_data.kind == KIND_PIXEL);
  assign north_ld = accept && (in_data.kind == KIND_NORTH) &&
                    (32'(in_data.halo_index) < MAX_WIDTH) &&
                    (32'(in_data.halo_bin) < MAX_BINS);
  assign west_ld  = accept && (in_data.kind == KIND_WEST) &&
                    (32'(in_data.halo_index) < MAX_HEIGHT) &&
                    (32'(in_data.halo_bin) < MAX_BINS);
  assign north_ld_addr = LAW'(32'(in_data.halo_index) * MAX_BINS + 32'(in_data.halo_bin));
  assign west_ld_addr  = WAW'(32'(in_data.halo_index) * MAX_BINS + 32'(in_data.halo_bin));

  // bin loop control: the loop only moves when the output slot can take a beat
  assign advance  = !rv_r || !out_valid_r || !out_stall;
  assign issue    = (state_r == ST_RUN) && advance && (iss_r < nb_r);
  assign compute  = rv_r && advance;
  assign finish   = (state_r == ST_RUN) && advance && (iss_r == nb_r);
  assign line_ra  = LAW'(32'(col_r) * MAX_BINS + 32'(iss_r));
  assign west_ra  = WAW'(32'(row_r) * MAX_BINS + 32'(iss_r));
  assign last_now = (32'(rb_r) == 32'(nb_r) - 32'd1);

  // bin hit: acc_r holds bin * stride, a zero stride never hits
  assign hit = (ACC_W'(p256_r) >= acc_r) &&
               (ACC_W'(p256_r) < acc_r + ACC_W'(bin_stride_r));

  // count update for the bin whose read data is back
  always_comb begin
    prev = (col_r == '0) ? west_rdata : row_run_r[rb_r];
    rc   = prev + 32'(hit);
    tc   = rc + line_rdata;
  end

  // memory write ports: loads while idle, write-back while running
  always_comb begin
    line_we    = compute || north_ld;
    line_waddr = compute ? line_wa_r : north_ld_addr;
    line_wdata = compute ? tc : in_data.halo_value;
    west_we    = (compute && east_r) || west_ld;
    west_waddr = compute ? west_wa_r : west_ld_addr;
    west_wdata = compute ? rc : in_data.halo_value;
  end

  ihist_ram #(.WIDTH(32), .DEPTH(LDEPTH)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .re    (issue),
    .raddr (line_ra),
    .rdata (line_rdata)
  );

  ihist_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_west_ram (
    .clk   (clk),
    .we    (west_we),
    .waddr (west_waddr),
    .wdata (west_wdata),
    .re    (issue),
    .raddr (west_ra),
    .rdata (west_rdata)
  );

  // row counts of the previous column
  always_ff @(posedge clk) begin
    if (compute) begin
      row_run_r[rb_r] <= rc;
    end
  end

  // state, configuration, positions, loop and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      tile_width_r  <= 9'd64;
      tile_height_r <= 9'd64;
      bin_count_r   <= 5'd16;
      bin_stride_r  <= 16'd4096;
      col_pos_r     <= '0;
      row_pos_r     <= '0;
      rv_r          <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TILE_WIDTH:  tile_width_r  <= cfg_wdata[8:0];
          REG_TILE_HEIGHT: tile_height_r <= cfg_wdata[8:0];
          REG_BIN_COUNT:   bin_count_r   <= cfg_wdata[4:0];
          REG_BIN_STRIDE:  bin_stride_r  <= cfg_wdata;
          default: ;
        endcase
      end

      // pixel start: latch context and step the raster position
      unique case (state_r)
        ST_IDLE: begin
          if (pix_acc) begin
            state_r <= ST_RUN;
            col_r   <= col_eff;
            row_r   <= row_eff;
            east_r  <= (col_eff == w_eff - POS_W'(1));
            south_r <= (row_eff == h_eff - POS_W'(1));
            p256_r  <= {in_data.pixel_value, 8'd0};
            nb_r    <= nb_eff;
            iss_r   <= '0;
            acc_r   <= '0;
            if (col_inc >= w_eff) begin
              col_pos_r <= '0;
              row_pos_r <= (row_inc >= h_eff) ? '0 : row_inc;
            end else begin
              col_pos_r <= col_inc;
              row_pos_r <= row_eff;
            end
          end
        end
        ST_RUN: begin
          if (finish) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // read issue for the next bin
      if (advance) begin
        rv_r <= issue;
      end
      if (issue) begin
        iss_r     <= iss_r + KW'(1);
        rb_r      <= BW'(iss_r);
        line_wa_r <= line_ra;
        west_wa_r <= west_ra;
      end
      if (compute) begin
        acc_r <= acc_r + ACC_W'(bin_stride_r);
      end

      // output beat register
      if (compute) begin
        out_valid_r              <= 1'b1;
        out_data_r.bin_index     <= 4'(rb_r);
        out_data_r.row_count     <= rc;
        out_data_r.total_count   <= tc;
        out_data_r.pixel_column  <= col_r[7:0];
        out_data_r.pixel_row     <= row_r[7:0];
        out_data_r.last_bin      <= last_now;
        out_data_r.east_edge     <= east_r;
        out_data_r.south_edge    <= south_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // a new output beat comes only from the bin loop
  a_beat_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == ST_RUN))
    else $error("output beat raised outside the bin loop");

  // a pending read only exists while a pixel is worked on
  a_read_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r |-> (state_r == ST_RUN))
    else $error("pending memory read while idle");

  // the last bin of a pixel ends the loop
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (compute && last_now) |=> (state_r == ST_IDLE))
    else $error("bin loop did not end after its last bin");

  // halo loads never collide with the write-back
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (north_ld || west_ld) |-> (!compute && state_r == ST_IDLE))
    else $error("halo load during the bin loop");

  // a finished beat is held while stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(out_valid_r && out_stall)) |-> (out_valid_r && $stable(out_data_r)))
    else $error("stalled output beat changed");

endmodule

@@ sim/ihist_count_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihist_count_checker
// Watches the pixel, count and register channels of the integral histogram
// tile. It keeps its own copy of the halo memories and tile position, works
// out the count beats that each accepted pixel produces, and compares every
// accepted count beat field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module ihist_count_checker
  import ihist_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_BINS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_beat_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_beat_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    pending,
  output int                    beats_checked
);

  localparam int PRINT_LIMIT = 40;

  // register copies
  logic [8:0]  tile_w_reg;
  logic [8:0]  tile_h_reg;
  logic [4:0]  bins_reg;
  logic [15:0] stride_reg;

  // halo memories, running row counts and the next pixel position
  logic [31:0] line_mem [MAX_WIDTH*MAX_BINS];
  logic [31:0] west_mem [MAX_HEIGHT*MAX_BINS];
  logic [31:0] row_prev [MAX_BINS];
  int unsigned col_pos;
  int unsigned row_pos;

  out_beat_t expected_counts [$];
  int        printed;

  function automatic int unsigned fit_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (printed < PRINT_LIMIT) begin
      printed++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    end
  endtask

  // halo loads; the unused kind falls through and changes nothing
  task automatic store_halo(in_beat_t b);
    int unsigned slot;
    slot = b.halo_index * MAX_BINS + b.halo_bin;
    if (b.kind == KIND_WEST && b.halo_index < MAX_HEIGHT && b.halo_bin < MAX_BINS) begin
      west_mem[slot] = b.halo_value;
    end else if (b.kind == KIND_NORTH && b.halo_index < MAX_WIDTH &&
                 b.halo_bin < MAX_BINS) begin
      line_mem[slot] = b.halo_value;
    end
  endtask

  // one pixel: update every bin in use and queue its count beats
  task automatic predict_pixel(logic [7:0] pix);
    int unsigned w, h, nb, bin, b;
    bit          hit, east, south;
    logic [31:0] rc, tc;
    out_beat_t   e;
    w  = fit_dim(tile_w_reg, MAX_WIDTH);
    h  = fit_dim(tile_h_reg, MAX_HEIGHT);
    nb = (bins_reg > MAX_BINS) ? MAX_BINS : bins_reg;
    // geometry may have shrunk since the last pixel
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    east  = (col_pos == w - 1);
    south = (row_pos == h - 1);
    hit   = (stride_reg != 0);
    bin   = hit ? (32'(pix) * 32'd256) / 32'(stride_reg) : 0;
    for (b = 0; b < nb; b++) begin
      rc = ((col_pos == 0) ? west_mem[row_pos*MAX_BINS + b] : row_prev[b]) +
           ((hit && bin == b) ? 32'd1 : 32'd0);
      tc = rc + line_mem[col_pos*MAX_BINS + b];
      row_prev[b] = rc;
      line_mem[col_pos*MAX_BINS + b] = tc;
      if (east) west_mem[row_pos*MAX_BINS + b] = rc;
      e.bin_index    = 4'(b);
      e.row_count    = rc;
      e.total_count  = tc;
      e.pixel_column = 8'(col_pos);
      e.pixel_row    = 8'(row_pos);
      e.last_bin     = (b == nb - 1);
      e.east_edge    = east;
      e.south_edge   = south;
      expected_counts.push_back(e);
    end
    // raster advance
    col_pos = col_pos + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row_pos + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_beat(out_beat_t got);
    out_beat_t want;
    beats_checked++;
    if (expected_counts.size() == 0) begin
      report_mismatch("count beat with nothing owed", got.row_count, 32'd0);
    end else begin
      want = expected_counts.pop_front();
      if (got.bin_index !== want.bin_index)
        report_mismatch("bin_index", 32'(got.bin_index), 32'(want.bin_index));
      if (got.row_count !== want.row_count)
        report_mismatch("row_count", got.row_count, want.row_count);
      if (got.total_count !== want.total_count)
        report_mismatch("total_count", got.total_count, want.total_count);
      if (got.pixel_column !== want.pixel_column)
        report_mismatch("pixel_column", 32'(got.pixel_column), 32'(want.pixel_column));
      if (got.pixel_row !== want.pixel_row)
        report_mismatch("pixel_row", 32'(got.pixel_row), 32'(want.pixel_row));
      if (got.last_bin !== want.last_bin)
        report_mismatch("last_bin", 32'(got.last_bin), 32'(want.last_bin));
      if (got.east_edge !== want.east_edge)
        report_mismatch("east_edge", 32'(got.east_edge), 32'(want.east_edge));
      if (got.south_edge !== want.south_edge)
        report_mismatch("south_edge", 32'(got.south_edge), 32'(want.south_edge));
    end
  endtask

  // sample all three channels at the clock edge; count beats before new pixels
  always @(posedge clk) begin
    if (!rst_n) begin
      tile_w_reg    = 9'd64;
      tile_h_reg    = 9'd64;
      bins_reg      = 5'd16;
      stride_reg    = 16'd4096;
      col_pos       = 0;
      row_pos       = 0;
      errors        = 0;
      beats_checked = 0;
      printed       = 0;
      expected_counts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TILE_WIDTH:  tile_w_reg = cfg_wdata[8:0];
          REG_TILE_HEIGHT: tile_h_reg = cfg_wdata[8:0];
          REG_BIN_COUNT:   bins_reg   = cfg_wdata[4:0];
          REG_BIN_STRIDE:  stride_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_beat(out_data);
      if (in_valid && !in_stall) begin
        if (in_data.kind == KIND_PIXEL) predict_pixel(in_data.pixel_value);
        else store_halo(in_data);
      end
    end
    pending <= expected_counts.size();
  end

endmodule

@@ sim/tb_integral_histogram_tile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integral_histogram_tile
// Drives pixel and halo beats and register writes into the integral histogram
// tile: a directed pass over edges, bin limits and geometry changes, then
// random tiles with random idling and back-pressure. Halo words are loaded
// just before a pixel first needs them. The checker does all comparing.
// ----------------------------------------------------------------------------
module tb_integral_histogram_tile;
  import ihist_pkg::*;

  localparam int MAX_WIDTH     = 256;
  localparam int MAX_HEIGHT    = 256;
  localparam int MAX_BINS      = 16;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 2000;
  localparam int ITEM_GOAL     = 210;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int errors;
  int pending;
  int beats_checked;

  // stimulus controls shared with the stall process
  bit quiet     = 1'b0;
  bit hold_req  = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;

  int items_sent     = 0;
  int pixels_sent    = 0;
  int loads_sent     = 0;
  int ignored_sent   = 0;
  int settings_count = 0;

  // tile position and settings as the block will see them, for halo loading
  int unsigned eff_w, eff_h, eff_nb;
  int unsigned pos_col = 0;
  int unsigned pos_row = 0;
  bit west_done  [MAX_HEIGHT][MAX_BINS];
  bit north_done [MAX_WIDTH][MAX_BINS];

  always #2 clk = ~clk;

  integral_histogram_tile #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_BINS  (MAX_BINS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  ihist_count_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_BINS  (MAX_BINS)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .errors       (errors),
    .pending      (pending),
    .beats_checked(beats_checked)
  );

  // count-side stall: random, quiet stretches, and a long requested hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 33);
    end
  end

  // watchdog on cycles with no beat moving on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned fit_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // halo counts lean toward the wrap point
  function automatic logic [31:0] pick_count();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFFF - $urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // offer one beat after a random gap and wait for it to be taken
  task automatic send_beat(in_beat_t b);
    items_sent++;
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_load(logic [1:0] kind, int unsigned idx, int unsigned bin);
    in_beat_t b;
    b            = in_beat_t'({$urandom, $urandom});
    b.kind       = kind;
    b.halo_index = 8'(idx);
    b.halo_bin   = 4'(bin);
    b.halo_value = pick_count();
    if (kind == KIND_WEST) west_done[idx][bin] = 1'b1;
    else north_done[idx][bin] = 1'b1;
    loads_sent++;
    send_beat(b);
  endtask

  task automatic send_ignored();
    in_beat_t b;
    b      = in_beat_t'({$urandom, $urandom});
    b.kind = KIND_UNUSED;
    ignored_sent++;
    send_beat(b);
  endtask

  // load any halo word this pixel will read, then send it
  task automatic send_pixel(logic [7:0] pix);
    in_beat_t    b;
    int unsigned bin;
    if (pos_col >= eff_w) pos_col = 0;
    if (pos_row >= eff_h) pos_row = 0;
    for (bin = 0; bin < eff_nb; bin++) begin
      if (pos_col == 0 && !west_done[pos_row][bin]) send_load(KIND_WEST, pos_row, bin);
      if (!north_done[pos_col][bin]) send_load(KIND_NORTH, pos_col, bin);
    end
    b             = in_beat_t'({$urandom, $urandom});
    b.kind        = KIND_PIXEL;
    b.pixel_value = pix;
    pixels_sent++;
    send_beat(b);
    pos_col++;
    if (pos_col >= eff_w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= eff_h) pos_row = 0;
    end
  endtask

  // drop valid, let every owed count beat arrive, then wait out the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // write all four registers, with junk in the unused upper bits of the first three
  task automatic apply_settings(int unsigned w, int unsigned h, int unsigned nb,
                                int unsigned stride);
    int bad_lo;
    bad_lo = int'(REG_BIN_STRIDE) + 1;
    settle();
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(255, bad_lo)), CFG_DATA_W'($urandom));
    write_reg(REG_TILE_WIDTH,  {7'($urandom), 9'(w)});
    write_reg(REG_TILE_HEIGHT, {7'($urandom), 9'(h)});
    write_reg(REG_BIN_COUNT,   {11'($urandom), 5'(nb)});
    write_reg(REG_BIN_STRIDE,  16'(stride));
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(255, bad_lo)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    eff_w  = fit_dim(w & 9'h1FF, MAX_WIDTH);
    eff_h  = fit_dim(h & 9'h1FF, MAX_HEIGHT);
    eff_nb = ((nb & 5'h1F) > MAX_BINS) ? MAX_BINS : (nb & 5'h1F);
    settings_count++;
  endtask

  // random settings, small tiles most of the time
  task automatic random_settings();
    int unsigned w, h, nb, stride, r;
    r = $urandom_range(9);
    w = (r == 0) ? 0 : (r == 1) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    r = $urandom_range(9);
    h = (r == 0) ? 0 : (r == 1) ? $urandom_range(511, 257) : $urandom_range(6, 1);
    r = $urandom_range(19);
    nb = (r == 0) ? 0 : (r == 1) ? $urandom_range(31, 17) : $urandom_range(16, 1);
    case ($urandom_range(9))
      0:       stride = 256;
      1:       stride = 4096;
      2:       stride = $urandom_range(300, 1);
      3:       stride = 65535;
      4:       stride = ($urandom_range(3) == 0) ? 0 : 512;
      default: stride = $urandom_range(65535, 1);
    endcase
    apply_settings(w, h, nb, stride);
  endtask

  // mostly pixels, with halo rewrites and ignored beats mixed in
  task automatic random_items(int n);
    int i, r;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 80)
        send_pixel(pick_pixel());
      else if (r < 90)
        send_load($urandom_range(1) ? KIND_WEST : KIND_NORTH,
                  $urandom_range(255), $urandom_range(15));
      else
        send_ignored();
    end
  endtask

  initial begin
    int phase;
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-pixel tile with all bins, so every running count gets written
    apply_settings(1, 1, 16, 4096);
    write_reg(8'hFF, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_pixel(8'd0);
    send_pixel(8'd15);
    send_pixel(8'd16);
    send_pixel(8'd255);
    send_pixel(8'd128);

    // one whole 3x2 tile, bin equals pixel, two pixels past the last bin
    apply_settings(3, 2, 4, 256);
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'd2);
    send_pixel(8'd3);
    send_pixel(8'd4);
    send_pixel(8'd255);

    // zero stride selects nothing; an unused kind is dropped
    apply_settings(2, 2, 3, 0);
    send_pixel(8'd77);
    send_ignored();
    send_pixel(8'd255);

    // no bins in use, then zero and oversized geometry with too many bins
    apply_settings(2, 1, 0, 256);
    send_pixel(8'd9);
    send_pixel(8'd200);
    apply_settings(0, 511, 31, 1);
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'd200);

    // widest stride, then the width shrinks under the current column
    apply_settings(8, 4, 2, 65535);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd128);
    apply_settings(2, 4, 2, 65535);
    send_pixel(8'd1);

    // the height shrinks under the current row
    apply_settings(1, 6, 2, 256);
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'd1);
    send_pixel(8'd5);
    apply_settings(1, 3, 2, 256);
    send_pixel(8'd1);

    // random tiles until the item budget is spent, every pressure phase included
    phase = 0;
    while (phase < 4 || items_sent < ITEM_GOAL) begin
      random_settings();
      n = $urandom_range(10, 4);
      quiet = (phase == 2);
      if (phase == 1) hold_req = 1'b1;
      if (phase == 3) begin
        random_items(n / 2);
        settle();
        random_items(n - n / 2);
      end else begin
        random_items(n);
      end
      quiet = 1'b0;
      phase++;
    end

    // a few pixels at the widest tile and a saturated height
    apply_settings(256, 300, 1, $urandom_range(65535, 1));
    repeat (3) send_pixel(pick_pixel());

    settle();
    $display("covered %0d beats: %0d pixels, %0d halo loads, %0d ignored over %0d settings",
             items_sent, pixels_sent, loads_sent, ignored_sent, settings_count);
    $display("%0d count beats compared, %0d mismatches", beats_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
